### design/nhdt_pkg.sv
// ----------------------------------------------------------------------------
// nhdt_pkg
// Shared types and constants of the NMEA HDT sentence parser.
// ----------------------------------------------------------------------------
package nhdt_pkg;

  localparam int unsigned MAX_LINE_LEN_DEF = 128;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_H     = 8'h48;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_T     = 8'h54;

  // Magnitude ceiling of the heading accumulator: 2^31.
  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  // Snapshot of the line state that the result formatter needs.
  typedef struct packed {
    logic [7:0]  running_xor;
    logic [7:0]  sent_checksum;
    logic        hex_bad;
    logic [31:0] heading_acc;
    logic [1:0]  fraction_digits;
    logic        minus_seen;
    logic        number_bad;
    logic        digit_seen;
  } line_sum_t;

  typedef struct packed {
    logic [31:0] heading_millideg;
    logic        checksum_match;
    logic        heading_parsed;
  } result_t;

endpackage

### design/nhdt_line_state.sv
// ----------------------------------------------------------------------------
// nhdt_line_state
// Per-line parse state, updated by one character per step.
// ----------------------------------------------------------------------------
module nhdt_line_state #(
  parameter int unsigned MaxLineLen = nhdt_pkg::MAX_LINE_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output logic                 emit_o,
  output nhdt_pkg::line_sum_t  sum_o
);

  localparam int unsigned PosW = $clog2(MaxLineLen + 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      xor_q, xor_d;
  logic [1:0]      fcnt_q, fcnt_d;
  logic            hdr_q, hdr_d;
  logic            star_q, star_d;
  logic [1:0]      hcnt_q, hcnt_d;
  logic [7:0]      sent_q, sent_d;
  logic [31:0]     acc_q, acc_d;
  logic [1:0]      frac_q, frac_d;
  logic            dot_q, dot_d;
  logic            minus_q, minus_d;
  logic            bad_q, bad_d;
  logic            digit_q, digit_d;
  logic            hbad_q, hbad_d;

  function automatic logic [31:0] sat_mac(logic [31:0] acc, logic [3:0] d);
    logic [35:0] v;
    v = 36'(acc) * 36'd10 + 36'(d);
    return (v > 36'(nhdt_pkg::MAG_CAP)) ? nhdt_pkg::MAG_CAP : v[31:0];
  endfunction

  logic       is_dec, is_hex;
  logic [3:0] hex_val;

  always_comb begin
    is_dec  = (byte_i >= 8'h30) && (byte_i <= 8'h39);
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (is_dec) begin
      hex_val = byte_i[3:0];
    end else if ((byte_i >= 8'h41 && byte_i <= 8'h46) ||
                 (byte_i >= 8'h61 && byte_i <= 8'h66)) begin
      hex_val = 4'(byte_i[3:0] + 4'd9);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    pos_d   = pos_q;   xor_d   = xor_q;   fcnt_d  = fcnt_q;  hdr_d  = hdr_q;
    star_d  = star_q;  hcnt_d  = hcnt_q;  sent_d  = sent_q;  acc_d  = acc_q;
    frac_d  = frac_q;  dot_d   = dot_q;   minus_d = minus_q; bad_d  = bad_q;
    digit_d = digit_q; hbad_d  = hbad_q;
    emit_o  = 1'b0;

    if (step_i && byte_i == nhdt_pkg::CHAR_LF) begin
      emit_o  = (hcnt_q == 2'd2) && hdr_q && (fcnt_q >= 2'd2);
      pos_d   = '0;   xor_d  = '0;   fcnt_d  = '0;   hdr_d  = 1'b1;
      star_d  = 1'b0; hcnt_d = '0;   sent_d  = '0;   acc_d  = '0;
      frac_d  = '0;   dot_d  = 1'b0; minus_d = 1'b0; bad_d  = 1'b0;
      digit_d = 1'b0; hbad_d = 1'b0;
    end else if (step_i && byte_i != nhdt_pkg::CHAR_CR) begin
      if (pos_q >= PosW'(MaxLineLen)) begin
        hdr_d = 1'b0;
      end else begin
        pos_d = pos_q + 1'b1;
        if (star_q) begin
          if (hcnt_q < 2'd2) begin
            if (is_hex) sent_d = {sent_q[3:0], hex_val};
            else        hbad_d = 1'b1;
            hcnt_d = hcnt_q + 2'd1;
          end
        end else if (pos_q != '0 && byte_i == nhdt_pkg::CHAR_STAR) begin
          star_d = 1'b1;
        end else begin
          if (pos_q != '0) xor_d = xor_q ^ byte_i;
          if (byte_i == nhdt_pkg::CHAR_COMMA) begin
            if (fcnt_q == 2'd0 && pos_q != PosW'(6)) hdr_d = 1'b0;
            if (fcnt_q != 2'd3) fcnt_d = fcnt_q + 2'd1;
          end else if (fcnt_q == 2'd0) begin
            if (pos_q >= PosW'(6)) hdr_d = 1'b0;
            else if (pos_q == PosW'(3) && byte_i != nhdt_pkg::CHAR_H) hdr_d = 1'b0;
            else if (pos_q == PosW'(4) && byte_i != nhdt_pkg::CHAR_D) hdr_d = 1'b0;
            else if (pos_q == PosW'(5) && byte_i != nhdt_pkg::CHAR_T) hdr_d = 1'b0;
          end else if (fcnt_q == 2'd1) begin
            if (byte_i == nhdt_pkg::CHAR_MINUS) begin
              if (digit_q || dot_q || minus_q) bad_d = 1'b1;
              else minus_d = 1'b1;
            end else if (byte_i == nhdt_pkg::CHAR_DOT) begin
              if (dot_q) bad_d = 1'b1;
              else dot_d = 1'b1;
            end else if (is_dec) begin
              digit_d = 1'b1;
              if (!dot_q) begin
                acc_d = sat_mac(acc_q, byte_i[3:0]);
              end else if (frac_q != 2'd3) begin
                acc_d  = sat_mac(acc_q, byte_i[3:0]);
                frac_d = frac_q + 2'd1;
              end
            end else begin
              bad_d = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;   xor_q  <= '0;   fcnt_q  <= '0;   hdr_q  <= 1'b1;
      star_q  <= 1'b0; hcnt_q <= '0;   sent_q  <= '0;   acc_q  <= '0;
      frac_q  <= '0;   dot_q  <= 1'b0; minus_q <= 1'b0; bad_q  <= 1'b0;
      digit_q <= 1'b0; hbad_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;   xor_q  <= xor_d;   fcnt_q  <= fcnt_d;  hdr_q  <= hdr_d;
      star_q  <= star_d;  hcnt_q <= hcnt_d;  sent_q  <= sent_d;  acc_q  <= acc_d;
      frac_q  <= frac_d;  dot_q  <= dot_d;   minus_q <= minus_d; bad_q  <= bad_d;
      digit_q <= digit_d; hbad_q <= hbad_d;
    end
  end

  always_comb begin
    sum_o.running_xor     = xor_q;
    sum_o.sent_checksum   = sent_q;
    sum_o.hex_bad         = hbad_q;
    sum_o.heading_acc     = acc_q;
    sum_o.fraction_digits = frac_q;
    sum_o.minus_seen      = minus_q;
    sum_o.number_bad      = bad_q;
    sum_o.digit_seen      = digit_q;
  end

endmodule

### design/nhdt_result.sv
// ----------------------------------------------------------------------------
// nhdt_result
// Turns the line state at line feed into the heading and status flags.
// ----------------------------------------------------------------------------
module nhdt_result (
  input  nhdt_pkg::line_sum_t sum_i,
  output nhdt_pkg::result_t   res_o
);

  logic [9:0]  scale;
  logic [41:0] mag;
  logic [31:0] mag_sat;
  logic [7:0]  sent;
  logic        parsed;

  always_comb begin
    case (sum_i.fraction_digits)
      2'd0:    scale = 10'd1000;
      2'd1:    scale = 10'd100;
      2'd2:    scale = 10'd10;
      default: scale = 10'd1;
    endcase
    mag     = 42'(sum_i.heading_acc) * 42'(scale);
    mag_sat = (mag > 42'(nhdt_pkg::MAG_CAP)) ? nhdt_pkg::MAG_CAP : mag[31:0];
    parsed  = sum_i.digit_seen && !sum_i.number_bad;
    sent    = sum_i.hex_bad ? 8'h00 : sum_i.sent_checksum;

    res_o.heading_parsed = parsed;
    res_o.checksum_match = (sum_i.running_xor == sent);
    if (!parsed) begin
      res_o.heading_millideg = '0;
    end else if (sum_i.minus_seen) begin
      res_o.heading_millideg = 32'd0 - mag_sat;
    end else if (mag_sat > nhdt_pkg::POS_MAX) begin
      res_o.heading_millideg = nhdt_pkg::POS_MAX;
    end else begin
      res_o.heading_millideg = mag_sat;
    end
  end

endmodule

### design/nmea_hdt_sentence_parser.sv
// ----------------------------------------------------------------------------
// nmea_hdt_sentence_parser
// Byte-stream parser for NMEA 0183 true-heading sentences.
// ----------------------------------------------------------------------------
// Usage: feed the received character stream on the input channel, one byte
// per transaction (in_valid_i / in_ready_o / rx_byte_i). Each line feed that
// closes a well-formed heading sentence, one with a header of the heading
// type, at least two fields and a two-character checksum, yields one
// transaction on the output channel with the heading in thousandths of a
// degree, the checksum comparison and the number-parse flag. Other bytes and
// rejected lines yield nothing. Carriage returns are ignored.
// Throughput is one byte per cycle while the receiver does not stall; the
// parse state is a set of small running registers updated once per byte. On
// its way to the output a byte passes the input register, then the update
// and formatting logic into the result register. When the receiver stalls
// with a result pending, the byte in the input register waits, and the
// input channel keeps taking one more byte only while that register is
// empty. Reset clears both registers' valid flags and returns the parse
// state to the start of a line.
// ----------------------------------------------------------------------------
module nmea_hdt_sentence_parser #(
  parameter int unsigned MAX_LINE_LEN = nhdt_pkg::MAX_LINE_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] heading_millideg_o,
  output logic        checksum_match_o,
  output logic        heading_parsed_o
);

  logic                in_valid_q;
  logic [7:0]          byte_q;
  logic                out_valid_q;
  nhdt_pkg::result_t   res_q;
  nhdt_pkg::result_t   res_d;
  nhdt_pkg::line_sum_t sum;
  logic                emit;
  logic                out_free;
  logic                proceed;

  // The byte in the input register is consumed only when the result
  // register can take whatever it produces.
  assign out_free   = !out_valid_q || out_ready_i;
  assign proceed    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  nhdt_line_state #(
    .MaxLineLen(MAX_LINE_LEN)
  ) u_line (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(proceed),
    .byte_i(byte_q),
    .emit_o(emit),
    .sum_o (sum)
  );

  nhdt_result u_result (
    .sum_i(sum),
    .res_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (proceed) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proceed && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proceed && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign heading_millideg_o = res_q.heading_millideg;
  assign checksum_match_o   = res_q.checksum_match;
  assign heading_parsed_o   = res_q.heading_parsed;

endmodule
